// ===== hw/rtl/wrhp_pkg.sv =====
// shared widths, result record and defaults for the riff/wave parser
package wrhp_pkg;

  localparam int unsigned FileByteW  = 8;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned FormatW    = 2;
  localparam int unsigned ChannelW   = 16;
  localparam int unsigned RateW      = 32;
  localparam int unsigned BitsW      = 16;
  localparam int unsigned LengthW    = 32;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CfgAddrW   = 3;

  // result queue depth, at least 2 so that a byte with two results can enter
  localparam int unsigned OutDepthDefault = 4;

  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666d_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  typedef struct packed {
    logic                 kind;
    logic [FileByteW-1:0] audio_byte;
    logic                 chunk_start;
    logic [StatusW-1:0]   status;
    logic [FormatW-1:0]   format_code;
    logic [ChannelW-1:0]  channel_count;
    logic [RateW-1:0]     sample_rate;
    logic [BitsW-1:0]     sample_bits;
    logic [LengthW-1:0]   data_length;
    logic                 last;
  } result_t;

endpackage

// ===== hw/rtl/wrhp_if.sv =====
// byte input and result output channels of the riff/wave parser
interface wrhp_in_if;
  import wrhp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FileByteW-1:0] file_byte;

  modport source (output valid, output file_byte, input ready);
  modport sink (input valid, input file_byte, output ready);
endinterface

interface wrhp_out_if;
  import wrhp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [FileByteW-1:0] audio_byte;
  logic                 chunk_start;
  logic [StatusW-1:0]   status;
  logic [FormatW-1:0]   format_code;
  logic [ChannelW-1:0]  channel_count;
  logic [RateW-1:0]     sample_rate;
  logic [BitsW-1:0]     sample_bits;
  logic [LengthW-1:0]   data_length;
  logic                 last;

  modport source (
    output valid, output kind, output audio_byte, output chunk_start, output status,
    output format_code, output channel_count, output sample_rate, output sample_bits,
    output data_length, output last, input ready
  );
  modport sink (
    input valid, input kind, input audio_byte, input chunk_start, input status,
    input format_code, input channel_count, input sample_rate, input sample_bits,
    input data_length, input last, output ready
  );
endinterface

// ===== hw/rtl/wav_riff_header_parser_unit.sv =====
// riff/wave byte stream parser: chunk walk, fmt capture, data pass-through, summary
//
//   channel   dir   handshake        carries
//   in_i      in    valid/ready      file_byte, one request per file byte
//   out_o     out   valid/ready      audio byte or end-of-file summary
//   apb       in    psel/penable     file_length at byte address 0
//
// one file byte is taken per cycle, as long as input ready is high; its results
// land in a small result queue and leave one per cycle while out_o is ready; the
// final byte of a file can add a second result (summary) behind an audio byte.
// input ready drops only while the queue has no room for two results.
// reset returns the parser to the start of a file with file_length 1.
module wav_riff_header_parser_unit #(
  parameter int unsigned OutDepth = wrhp_pkg::OutDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  wrhp_in_if.sink                        in_i,
  wrhp_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wrhp_pkg::CfgAddrW-1:0]  paddr,
  input  logic [wrhp_pkg::CfgDataW-1:0]  pwdata,
  output logic [wrhp_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);
  import wrhp_pkg::*;

  localparam int unsigned PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  localparam logic [1:0] PhRiff   = 2'd0;
  localparam logic [1:0] PhHeader = 2'd1;
  localparam logic [1:0] PhBody   = 2'd2;
  localparam logic [1:0] PhStop   = 2'd3;

  localparam logic [1:0] CkOther = 2'd0;
  localparam logic [1:0] CkFmt   = 2'd1;
  localparam logic [1:0] CkData  = 2'd2;

  localparam logic [StatusW-1:0] StOk      = 3'd0;
  localparam logic [StatusW-1:0] StShort   = 3'd1;
  localparam logic [StatusW-1:0] StBadTag  = 3'd2;
  localparam logic [StatusW-1:0] StNoData  = 3'd3;
  localparam logic [StatusW-1:0] StZero    = 3'd4;
  localparam logic [StatusW-1:0] StBadBits = 3'd5;

  localparam logic [CfgAddrW-1:0] RegFileLength = '0;

  // configuration
  logic [LengthW-1:0] file_len_q;
  logic               cfg_wr;

  // parse state
  logic [31:0]         pos_q, pos_d;
  logic [1:0]          phase_q, phase_d;
  logic                tag_ok_q, tag_ok_d;
  logic [31:0]         tag_q, tag_d;
  logic [31:0]         len_q, len_d;
  logic [31:0]         left_q, left_d;
  logic [1:0]          ck_q, ck_d;
  logic                pad_q, pad_d;
  logic [ChannelW-1:0] ch_q, ch_d;
  logic [RateW-1:0]    rate_q, rate_d;
  logic [BitsW-1:0]    bits_q, bits_d;
  logic                seen_q, seen_d;
  logic [LengthW-1:0]  dlen_q, dlen_d;

  // per byte work
  logic                 accept;
  logic [FileByteW-1:0] b;
  logic [33:0]          pos_p1;
  logic                 final_byte;
  logic [31:0]          off;
  logic [31:0]          len_new;
  logic                 overrun;
  logic                 push_a, push_s;
  result_t              aud, summ;
  logic [StatusW-1:0]   status;
  logic [FormatW-1:0]   fmt;

  // pre-clear values of the kept fields for the summary
  logic                tag_ok_d_sum;
  logic                seen_sum;
  logic [ChannelW-1:0] ch_sum;
  logic [RateW-1:0]    rate_sum;
  logic [BitsW-1:0]    bits_sum;
  logic [LengthW-1:0]  dlen_sum;

  // result queue
  result_t         mem_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1, wr_ptr2, rd_ptr1;
  logic [CntW-1:0] cnt_q;
  logic            pop;
  result_t         head;

  // apb
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[CfgAddrW-1:2] == RegFileLength[CfgAddrW-1:2]);
  assign prdata = (paddr[CfgAddrW-1:2] == RegFileLength[CfgAddrW-1:2]) ? file_len_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len_q <= 32'd1;
    end else if (cfg_wr) begin
      file_len_q <= pwdata;
    end
  end

  assign accept = in_i.valid & in_i.ready;
  assign b      = in_i.file_byte;
  assign pos_p1 = {2'b00, pos_q} + 34'd1;
  assign final_byte = pos_p1 >= {2'b00, file_len_q};
  assign off    = len_q - left_q;

  // chunk length with the current byte placed, for the length bytes of a header
  always_comb begin
    len_new = len_q;
    case (left_q[1:0])
      2'd0:    len_new[7:0]   = len_q[7:0] | b;
      2'd1:    len_new[15:8]  = len_q[15:8] | b;
      2'd2:    len_new[23:16] = len_q[23:16] | b;
      default: len_new[31:24] = len_q[31:24] | b;
    endcase
  end

  assign overrun = (pos_p1 + {2'b00, len_new}) > {2'b00, file_len_q};

  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    tag_ok_d = tag_ok_q;
    tag_d    = tag_q;
    len_d    = len_q;
    left_d   = left_q;
    ck_d     = ck_q;
    pad_d    = pad_q;
    ch_d     = ch_q;
    rate_d   = rate_q;
    bits_d   = bits_q;
    seen_d   = seen_q;
    dlen_d   = dlen_q;
    push_a   = 1'b0;

    case (phase_q)
      PhRiff: begin
        // position stays below 12 in this phase
        if (pos_q[3:0] < 4'd4 || (pos_q[3:0] >= 4'd8 && pos_q[3:0] < 4'd12)) begin
          tag_d = {tag_q[23:0], b};
        end
        if (pos_q[3:0] == 4'd3 && tag_d != TagRiff) begin
          tag_ok_d = 1'b0;
        end
        if (pos_q[3:0] == 4'd11) begin
          if (tag_d != TagWave) begin
            tag_ok_d = 1'b0;
          end
          tag_d   = '0;
          left_d  = '0;
          phase_d = tag_ok_d ? PhHeader : PhStop;
        end
      end
      PhHeader: begin
        if (pad_q) begin
          pad_d = 1'b0;
        end else begin
          if (left_q[2] == 1'b0) begin
            tag_d = {tag_q[23:0], b};
          end else begin
            len_d = len_new;
          end
          left_d = left_q + 32'd1;
          if (left_q[2:0] == 3'd7) begin
            if (overrun) begin
              phase_d = PhStop;
            end else if (tag_q == TagFmt && len_new < 32'd16) begin
              // fmt too short to hold the fields
              phase_d = PhStop;
            end else begin
              ck_d = CkOther;
              if (tag_q == TagFmt) begin
                ck_d = CkFmt;
              end else if (tag_q == TagData) begin
                ck_d   = CkData;
                seen_d = 1'b1;
                dlen_d = len_new;
              end
              if (len_new == 32'd0) begin
                left_d  = '0;
                tag_d   = '0;
                phase_d = PhHeader;
              end else begin
                left_d  = len_new;
                phase_d = PhBody;
              end
            end
          end
        end
      end
      PhBody: begin
        if (ck_q == CkFmt && off[31:4] == 28'd0) begin
          case (off[3:0])
            4'd2:    ch_d[7:0]     = b;
            4'd3:    ch_d[15:8]    = b;
            4'd4:    rate_d[7:0]   = b;
            4'd5:    rate_d[15:8]  = b;
            4'd6:    rate_d[23:16] = b;
            4'd7:    rate_d[31:24] = b;
            4'd14:   bits_d[7:0]   = b;
            4'd15:   bits_d[15:8]  = b;
            default: ;
          endcase
        end else if (ck_q == CkData) begin
          push_a = 1'b1;
        end
        left_d = left_q - 32'd1;
        if (left_q == 32'd1) begin
          pad_d   = len_q[0];
          tag_d   = '0;
          len_d   = '0;
          phase_d = PhHeader;
        end
      end
      default: ;
    endcase

    pos_d = pos_q + 32'd1;

    if (final_byte) begin
      // new file starts on the next byte
      pos_d    = '0;
      phase_d  = PhRiff;
      tag_ok_d = 1'b1;
      tag_d    = '0;
      len_d    = '0;
      left_d   = '0;
      ck_d     = CkOther;
      pad_d    = 1'b0;
      ch_d     = '0;
      rate_d   = '0;
      bits_d   = '0;
      seen_d   = 1'b0;
      dlen_d   = '0;
    end
  end

  // summary from the fields as they stand after this byte
  always_comb begin
    fmt = '0;
    if (file_len_q < 32'd12) begin
      status = StShort;
    end else if (!tag_ok_d_sum) begin
      status = StBadTag;
    end else if (!seen_sum) begin
      status = StNoData;
    end else if (ch_sum == '0 || bits_sum == '0 || rate_sum == '0) begin
      status = StZero;
    end else if (bits_sum != 16'd8 && bits_sum != 16'd16) begin
      status = StBadBits;
    end else begin
      status = StOk;
      fmt    = {bits_sum == 16'd16, ch_sum != 16'd1};
    end
  end

  always_comb begin
    tag_ok_d_sum = tag_ok_q;
    seen_sum     = seen_q;
    ch_sum       = ch_q;
    rate_sum     = rate_q;
    bits_sum     = bits_q;
    dlen_sum     = dlen_q;
    case (phase_q)
      PhRiff: begin
        if (pos_q[3:0] == 4'd3 && {tag_q[23:0], b} != TagRiff) begin
          tag_ok_d_sum = 1'b0;
        end
        if (pos_q[3:0] == 4'd11 && {tag_q[23:0], b} != TagWave) begin
          tag_ok_d_sum = 1'b0;
        end
      end
      PhHeader: begin
        if (!pad_q && left_q[2:0] == 3'd7 && !overrun && tag_q == TagData) begin
          seen_sum = 1'b1;
          dlen_sum = len_new;
        end
      end
      PhBody: begin
        if (ck_q == CkFmt && off[31:4] == 28'd0) begin
          case (off[3:0])
            4'd2:    ch_sum[7:0]     = b;
            4'd3:    ch_sum[15:8]    = b;
            4'd4:    rate_sum[7:0]   = b;
            4'd5:    rate_sum[15:8]  = b;
            4'd6:    rate_sum[23:16] = b;
            4'd7:    rate_sum[31:24] = b;
            4'd14:   bits_sum[7:0]   = b;
            4'd15:   bits_sum[15:8]  = b;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign push_s = final_byte;

  always_comb begin
    aud             = '0;
    aud.kind        = 1'b0;
    aud.audio_byte  = b;
    aud.chunk_start = (off == 32'd0);

    summ               = '0;
    summ.kind          = 1'b1;
    summ.status        = status;
    summ.format_code   = fmt;
    summ.channel_count = ch_sum;
    summ.sample_rate   = rate_sum;
    summ.sample_bits   = bits_sum;
    summ.data_length   = dlen_sum;
    summ.last          = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= PhRiff;
      tag_ok_q <= 1'b1;
      tag_q    <= '0;
      len_q    <= '0;
      left_q   <= '0;
      ck_q     <= CkOther;
      pad_q    <= 1'b0;
      ch_q     <= '0;
      rate_q   <= '0;
      bits_q   <= '0;
      seen_q   <= 1'b0;
      dlen_q   <= '0;
    end else if (accept) begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      tag_ok_q <= tag_ok_d;
      tag_q    <= tag_d;
      len_q    <= len_d;
      left_q   <= left_d;
      ck_q     <= ck_d;
      pad_q    <= pad_d;
      ch_q     <= ch_d;
      rate_q   <= rate_d;
      bits_q   <= bits_d;
      seen_q   <= seen_d;
      dlen_q   <= dlen_d;
    end
  end

  // result queue
  assign wr_ptr1 = (wr_ptr_q == PtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign wr_ptr2 = (wr_ptr1 == PtrW'(OutDepth - 1)) ? '0 : wr_ptr1 + 1'b1;
  assign rd_ptr1 = (rd_ptr_q == PtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + 1'b1;

  assign in_i.ready = (cnt_q <= CntW'(OutDepth - 2));
  assign pop        = out_o.valid & out_o.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (push_a) begin
        mem_q[wr_ptr_q] <= aud;
      end
      if (push_s) begin
        mem_q[push_a ? wr_ptr1 : wr_ptr_q] <= summ;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        if (push_a && push_s) begin
          wr_ptr_q <= wr_ptr2;
        end else if (push_a || push_s) begin
          wr_ptr_q <= wr_ptr1;
        end
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr1;
      end
      cnt_q <= cnt_q + CntW'(accept & push_a) + CntW'(accept & push_s) - CntW'(pop);
    end
  end

  assign head = mem_q[rd_ptr_q];

  assign out_o.valid         = (cnt_q != '0);
  assign out_o.kind          = head.kind;
  assign out_o.audio_byte    = head.audio_byte;
  assign out_o.chunk_start   = head.chunk_start;
  assign out_o.status        = head.status;
  assign out_o.format_code   = head.format_code;
  assign out_o.channel_count = head.channel_count;
  assign out_o.sample_rate   = head.sample_rate;
  assign out_o.sample_bits   = head.sample_bits;
  assign out_o.data_length   = head.data_length;
  assign out_o.last          = head.last;

endmodule

// ===== tb/sv/wrhp_result_checker.sv =====
`timescale 1ns / 1ps
// result checker for the riff/wave parser: tracks the parse, predicts results, compares, checks file_length reads
module wrhp_result_checker
  import wrhp_pkg::*;
#(
  parameter logic [CfgAddrW-1:0] FileLengthAddr = '0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  wrhp_in_if                  byte_in_i,
  wrhp_out_if                 result_in_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [CfgDataW-1:0] pwdata_i,
  input  logic [CfgDataW-1:0] prdata_i,
  input  logic                pready_i,
  output int unsigned         results_due_o,
  output int unsigned         error_count_o
);

  typedef enum logic [1:0] {PhRiff, PhHeader, PhBody, PhStop} phase_e;
  typedef enum logic [1:0] {ChunkOther, ChunkFmt, ChunkData} chunk_e;
  typedef enum logic [2:0] {
    StOk, StShortFile, StBadTag, StNoData, StZeroField, StBadBits
  } status_e;

  localparam int unsigned MinFileBytes = 12;
  localparam int unsigned MinFmtBytes  = 16;
  localparam int unsigned HeaderBytes  = 8;
  localparam int unsigned FmtChanOff   = 2;
  localparam int unsigned FmtRateOff   = 4;
  localparam int unsigned FmtBitsOff   = 14;
  localparam int unsigned MaxShown     = 10;

  logic [31:0] file_len;
  logic [31:0] byte_pos;
  logic [31:0] tag_acc;
  logic [31:0] chunk_len;
  logic [31:0] left;
  logic [31:0] rate;
  logic [31:0] data_len;
  logic [15:0] chan;
  logic [15:0] bits;
  phase_e      phase;
  chunk_e      ckind;
  logic        tags_good;
  logic        pad_skip;
  logic        have_data;

  result_t     parsed_results[$];
  result_t     want;
  result_t     got;
  int unsigned error_total = 0;
  int unsigned due_count = 0;

  assign results_due_o = due_count;
  assign error_count_o = error_total;

  function automatic void clear_file();
    byte_pos  = '0;
    phase     = PhRiff;
    tags_good = 1'b1;
    tag_acc   = '0;
    chunk_len = '0;
    left      = '0;
    ckind     = ChunkOther;
    pad_skip  = 1'b0;
    chan      = '0;
    rate      = '0;
    bits      = '0;
    have_data = 1'b0;
    data_len  = '0;
  endfunction

  function automatic string show(result_t r);
    return $sformatf(
      "kind=%0d byte=%02h start=%0d status=%0d fmt=%0d ch=%0d rate=%0d bits=%0d len=%0d last=%0d",
      r.kind, r.audio_byte, r.chunk_start, r.status, r.format_code, r.channel_count,
      r.sample_rate, r.sample_bits, r.data_length, r.last);
  endfunction

  function automatic void note_error(string msg);
    error_total++;
    if (error_total <= MaxShown) $display("%s", msg);
  endfunction

  // one file byte through the parse; queues the audio byte and/or summary it causes
  task automatic parse_file_byte(input logic [7:0] b);
    logic        at_end;
    logic [31:0] off;
    logic [1:0]  fmt;
    status_e     st;
    result_t     r;
    at_end = ({32'd0, byte_pos} + 64'd1) >= {32'd0, file_len};
    case (phase)
      PhRiff: begin
        if (byte_pos < 4 || (byte_pos >= 8 && byte_pos < MinFileBytes)) begin
          tag_acc = {tag_acc[23:0], b};
        end
        if (byte_pos == 3 && tag_acc != TagRiff) tags_good = 1'b0;
        if (byte_pos == MinFileBytes - 1) begin
          if (tag_acc != TagWave) tags_good = 1'b0;
          tag_acc = '0;
          left    = '0;
          phase   = tags_good ? PhHeader : PhStop;
        end
      end
      PhHeader: begin
        if (pad_skip) begin
          pad_skip = 1'b0;
        end else begin
          // tag big-endian, length little-endian
          if (left < 4) tag_acc = {tag_acc[23:0], b};
          else chunk_len = chunk_len | (32'(b) << (8 * (left - 4)));
          left = left + 1;
          if (left == HeaderBytes) begin
            if ({32'd0, byte_pos} + 64'd1 + {32'd0, chunk_len} > {32'd0, file_len}) begin
              phase = PhStop;
            end else if (tag_acc == TagFmt && chunk_len < MinFmtBytes) begin
              phase = PhStop;
            end else begin
              ckind = ChunkOther;
              if (tag_acc == TagFmt) begin
                ckind = ChunkFmt;
              end else if (tag_acc == TagData) begin
                ckind     = ChunkData;
                have_data = 1'b1;
                data_len  = chunk_len;
              end
              if (chunk_len == 0) begin
                left    = '0;
                tag_acc = '0;
                phase   = PhHeader;
              end else begin
                left  = chunk_len;
                phase = PhBody;
              end
            end
          end
        end
      end
      PhBody: begin
        off = chunk_len - left;
        if (ckind == ChunkFmt) begin
          if (off == FmtChanOff) chan[7:0] = b;
          else if (off == FmtChanOff + 1) chan[15:8] = b;
          else if (off >= FmtRateOff && off < FmtRateOff + 4) rate[8 * (off - FmtRateOff) +: 8] = b;
          else if (off == FmtBitsOff) bits[7:0] = b;
          else if (off == FmtBitsOff + 1) bits[15:8] = b;
        end else if (ckind == ChunkData) begin
          r             = '0;
          r.audio_byte  = b;
          r.chunk_start = (off == 0);
          parsed_results.push_back(r);
        end
        left = left - 1;
        if (left == 0) begin
          pad_skip  = chunk_len[0];
          tag_acc   = '0;
          chunk_len = '0;
          phase     = PhHeader;
        end
      end
      default: ;  // walk stopped, byte ignored
    endcase
    byte_pos = byte_pos + 1;

    if (at_end) begin
      fmt = '0;
      if (file_len < MinFileBytes) st = StShortFile;
      else if (!tags_good) st = StBadTag;
      else if (!have_data) st = StNoData;
      else if (chan == 0 || bits == 0 || rate == 0) st = StZeroField;
      else if (bits != 8 && bits != 16) st = StBadBits;
      else begin
        st  = StOk;
        fmt = {bits == 16, chan != 1};
      end
      r               = '0;
      r.kind          = 1'b1;
      r.status        = st;
      r.format_code   = fmt;
      r.channel_count = chan;
      r.sample_rate   = rate;
      r.sample_bits   = bits;
      r.data_length   = data_len;
      r.last          = 1'b1;
      parsed_results.push_back(r);
      clear_file();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len = 32'd1;
      clear_file();
      parsed_results.delete();
      due_count = 0;
    end else begin
      // results leave the result queue only after their byte is accepted, so compare before predicting
      if (result_in_i.valid && result_in_i.ready) begin
        got.kind          = result_in_i.kind;
        got.audio_byte    = result_in_i.audio_byte;
        got.chunk_start   = result_in_i.chunk_start;
        got.status        = result_in_i.status;
        got.format_code   = result_in_i.format_code;
        got.channel_count = result_in_i.channel_count;
        got.sample_rate   = result_in_i.sample_rate;
        got.sample_bits   = result_in_i.sample_bits;
        got.data_length   = result_in_i.data_length;
        got.last          = result_in_i.last;
        if (parsed_results.size() == 0) begin
          note_error({"unexpected result: ", show(got)});
        end else begin
          want = parsed_results.pop_front();
          if (got.kind !== want.kind || got.audio_byte !== want.audio_byte ||
              got.chunk_start !== want.chunk_start || got.status !== want.status ||
              got.format_code !== want.format_code ||
              got.channel_count !== want.channel_count ||
              got.sample_rate !== want.sample_rate || got.sample_bits !== want.sample_bits ||
              got.data_length !== want.data_length || got.last !== want.last) begin
            note_error({"result mismatch\n  expected ", show(want), "\n  actual   ", show(got)});
          end
        end
      end
      if (byte_in_i.valid && byte_in_i.ready) parse_file_byte(byte_in_i.file_byte);
      if (psel_i && penable_i && pready_i && paddr_i == FileLengthAddr) begin
        if (pwrite_i) begin
          file_len = pwdata_i;
        end else if (prdata_i !== file_len) begin
          note_error($sformatf("file_length read %08h, expected %08h", prdata_i, file_len));
        end
      end
      due_count = parsed_results.size();
    end
  end

endmodule

// ===== tb/sv/wav_riff_header_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the riff/wave parser: clock, reset, wav file stimulus and verdict
module wav_riff_header_parser_unit_tb;
  import wrhp_pkg::*;

  typedef enum int unsigned {
    CaseGood, CaseMulti, CaseEmptyData, CaseNoData, CaseBadTag, CaseZeroField,
    CaseBadBits, CaseOverrun, CaseShortFmt, CasePartHeader, CaseNoise, CaseCount
  } wav_case_e;

  typedef enum int unsigned {RxAlways, RxCoin, RxPeriodic} rx_mode_e;

  localparam logic [CfgAddrW-1:0] RegFileLength = '0;
  localparam int unsigned RandomBytes = 750;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned TimeoutNs   = 4_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  int unsigned         results_due;
  int unsigned         error_count;

  logic [7:0]  file_bytes[$];
  int unsigned burst_left = 0;
  rx_mode_e    rx_mode = RxAlways;
  int unsigned rx_left = 0;
  int unsigned rx_period = 2;
  int unsigned rx_tick = 0;

  wrhp_in_if  in_ch ();
  wrhp_out_if out_ch ();

  wav_riff_header_parser_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  wrhp_result_checker #(
    .FileLengthAddr (RegFileLength)
  ) i_result_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_in_i     (in_ch),
    .result_in_i   (out_ch),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_i      (prdata),
    .pready_i      (pready),
    .results_due_o (results_due),
    .error_count_o (error_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side stalls: always ready, coin flips, or ready in the first part of each rx_period
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(RxAlways, RxPeriodic));
      rx_period = $urandom_range(2, 9);
      rx_left   = $urandom_range(16, 160);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RxAlways: out_ch.ready <= 1'b1;
      RxCoin:   out_ch.ready <= 1'($urandom_range(0, 1));
      default:  out_ch.ready <= (rx_tick % rx_period) < 2;
    endcase
  end

  initial begin
    #(TimeoutNs);
    $display("wav_riff_header_parser_unit_tb: errors");
    $finish;
  end

  function automatic void put_le(input logic [31:0] v, input int unsigned n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8 * i +: 8]);
  endfunction

  function automatic void put_tag(input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(tag[8 * i +: 8]);
  endfunction

  function automatic void put_head(input logic [31:0] tag, input logic [31:0] len);
    put_tag(tag);
    put_le(len, 4);
  endfunction

  function automatic void put_body(input int unsigned len, input logic pad);
    for (int i = 0; i < len; i++) file_bytes.push_back(8'($urandom()));
    if (pad && len[0]) file_bytes.push_back(8'($urandom()));
  endfunction

  function automatic void put_riff();
    put_tag(TagRiff);
    put_le($urandom(), 4);
    put_tag(TagWave);
  endfunction

  function automatic void put_other();
    int unsigned len;
    len = $urandom_range(0, 5);
    put_head($urandom(), len);
    put_body(len, 1'b1);
  endfunction

  function automatic void put_data(input int unsigned len, input logic pad);
    put_head(TagData, len);
    put_body(len, pad);
  endfunction

  function automatic void put_fmt(input logic [15:0] ch, input logic [31:0] rt,
                                  input logic [15:0] bt);
    int unsigned extra;
    extra = $urandom_range(0, 3);
    put_head(TagFmt, 16 + extra);
    put_le($urandom(), 2);  // format tag, ignored
    put_le(ch, 2);
    put_le(rt, 4);
    put_le($urandom(), 6);  // byte rate and block align, ignored
    put_le(bt, 2);
    put_body(extra, 1'b1);
  endfunction

  function automatic logic [15:0] pick_channels();
    case ($urandom_range(0, 2))
      0:       return 16'd1;
      1:       return 16'd2;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    return $urandom_range(0, 1) ? 32'd44100 : 32'($urandom_range(1, 32'hffff_ffff));
  endfunction

  function automatic logic [15:0] pick_bits();
    return $urandom_range(0, 1) ? 16'd8 : 16'd16;
  endfunction

  function automatic void put_good_fmt();
    put_fmt(pick_channels(), pick_rate(), pick_bits());
  endfunction

  function automatic void build_file(input wav_case_e c);
    logic [15:0] ch;
    logic [15:0] bt;
    logic [31:0] rt;
    logic [31:0] tag;
    logic [31:0] len;
    logic        pad;
    int unsigned n;
    int unsigned idx;
    file_bytes.delete();
    case (c)
      CaseGood: begin
        put_riff();
        if ($urandom_range(0, 1)) put_other();
        put_good_fmt();
        if ($urandom_range(0, 1)) put_other();
        // an odd data chunk at the very end may drop its pad byte
        pad = $urandom_range(0, 3) != 0;
        put_data($urandom_range(0, 9), pad);
        if (pad && $urandom_range(0, 1)) put_other();
      end
      CaseMulti: begin
        put_riff();
        put_good_fmt();
        put_data($urandom_range(1, 6), 1'b1);
        if ($urandom_range(0, 1)) put_other();
        put_good_fmt();
        put_data($urandom_range(0, 6), 1'b1);
        if ($urandom_range(0, 1)) put_data(0, 1'b1);
      end
      CaseEmptyData: begin
        put_riff();
        put_good_fmt();
        put_data(0, 1'b1);
      end
      CaseNoData: begin
        put_riff();
        if ($urandom_range(0, 1)) put_good_fmt();
        if ($urandom_range(0, 1)) put_other();
      end
      CaseBadTag: begin
        put_riff();
        put_good_fmt();
        put_data($urandom_range(1, 6), 1'b1);
        idx = $urandom_range(0, 7);
        if (idx >= 4) idx += 4;
        file_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
      end
      CaseZeroField, CaseBadBits: begin
        ch = pick_channels();
        rt = pick_rate();
        bt = pick_bits();
        if (c == CaseBadBits) begin
          do bt = 16'($urandom_range(1, 65535)); while (bt == 8 || bt == 16);
        end else begin
          case ($urandom_range(0, 2))
            0:       ch = '0;
            1:       rt = '0;
            default: bt = '0;
          endcase
        end
        put_riff();
        put_fmt(ch, rt, bt);
        put_data($urandom_range(1, 6), 1'b1);
      end
      CaseOverrun: begin
        put_riff();
        if ($urandom_range(0, 1)) begin
          put_good_fmt();
          put_data($urandom_range(1, 4), 1'b1);
        end
        case ($urandom_range(0, 2))
          0:       tag = TagFmt;
          1:       tag = TagData;
          default: tag = $urandom();
        endcase
        // body needs len bytes but only n remain after the header
        n   = $urandom_range(0, 6);
        len = $urandom_range(0, 1) ? 32'hffff_ffff - $urandom_range(0, 3)
                                   : n + 1 + $urandom_range(0, 3);
        put_head(tag, len);
        put_body(n, 1'b0);
      end
      CaseShortFmt: begin
        put_riff();
        if ($urandom_range(0, 1)) put_data($urandom_range(1, 4), 1'b1);
        n = $urandom_range(0, 15);
        put_head(TagFmt, n);
        put_body(n, 1'b1);
        if ($urandom_range(0, 1)) put_data($urandom_range(1, 4), 1'b1);
      end
      CasePartHeader: begin
        put_riff();
        put_good_fmt();
        put_data($urandom_range(1, 5), 1'b1);
        put_body($urandom_range(1, 7), 1'b0);
      end
      default: begin
        if ($urandom_range(0, 1)) put_tag(TagRiff);
        put_body($urandom_range(1, 30), 1'b0);
      end
    endcase
  endfunction

  // every task below starts and ends at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    in_ch.valid     <= 1'b1;
    in_ch.file_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i]);
  endtask

  task automatic apb_access(input logic wr, input logic [CfgAddrW-1:0] addr,
                            input logic [CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // drain all outstanding results, then give bytes without results time to clear
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned fidx;
    int unsigned reps;
    int unsigned pick;
    wav_case_e   c;

    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.file_byte = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset length of one: every byte is a whole file
    apb_access(1'b0, RegFileLength, '0);
    send_byte(8'h00);
    send_byte(8'hff);
    settle();
    // zero length behaves like one
    apb_access(1'b1, RegFileLength, '0);
    send_byte(8'ha5);
    settle();
    // huge length: chunk length overflow past 32 bits must still stop the walk
    apb_access(1'b1, RegFileLength, '1);
    apb_access(1'b0, RegFileLength, '0);
    file_bytes.delete();
    put_riff();
    put_head(TagData, 32'hffff_fff0);
    send_file();
    settle();
    // shrinking the length mid-file ends the file on the next byte
    apb_access(1'b1, RegFileLength, 32'd1);
    send_byte(8'($urandom()));
    settle();

    sent = 0;
    fidx = 0;
    while (sent < RandomBytes) begin
      if (fidx < CaseCount) begin
        c = wav_case_e'(fidx);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) c = CaseGood;
        else if (pick < 55) c = CaseMulti;
        else c = wav_case_e'($urandom_range(CaseEmptyData, CaseNoise));
      end
      build_file(c);
      apb_access(1'b1, RegFileLength, file_bytes.size());
      if ($urandom_range(0, 3) == 0) apb_access(1'b0, RegFileLength, '0);
      // a repeat runs the next file on the same length without a rewrite
      reps = ($urandom_range(0, 3) == 0) ? 2 : 1;
      repeat (reps) send_file();
      sent += reps * file_bytes.size();
      settle();
      fidx++;
    end

    if (error_count == 0) begin
      $display("wav_riff_header_parser_unit_tb: clean");
    end else begin
      $display("wav_riff_header_parser_unit_tb: errors");
    end
    $finish;
  end

endmodule
